### rtl/stencil_offset_sequencer_macros.svh
// Assertion macros for the stencil offset sequencer.
`ifndef STENCIL_OFFSET_SEQUENCER_MACROS_SVH
`define STENCIL_OFFSET_SEQUENCER_MACROS_SVH

// consequent checked in the same cycle
`define SOS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define SOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sos_pkg.sv
// Types, constants and tables shared by the stencil offset sequencer.
package sos_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int MAX_RADIUS = 7;
  localparam int OUT_DIMS   = 4;
  localparam int DIGIT_W    = 4;
  localparam int OFF_W      = 4;
  localparam int POLE_W     = 16;
  localparam int DIM_IDX_W  = $clog2(MAX_DIMS);
  localparam int AXIS_DIM_W = $clog2(MAX_DIMS + 1);

  typedef enum logic [2:0] {
    KIND_DEFAULT  = 3'd0,
    KIND_AXIS     = 3'd1,
    KIND_AXIS_CTR = 3'd2,
    KIND_FULL     = 3'd3,
    KIND_FULL_CTR = 3'd4,
    KIND_14PT     = 3'd5,
    KIND_24CELL   = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    REG_DIMS   = 2'd0,
    REG_RADIUS = 2'd1,
    REG_KIND   = 2'd2
  } reg_e;

  typedef logic [MAX_DIMS-1:0][DIGIT_W-1:0] digits_t;
  typedef logic [OUT_DIMS-1:0][OFF_W-1:0]   offsets_t;

  typedef struct packed {
    logic [2:0] dims;
    logic [2:0] radius;
    logic [2:0] kind;
  } cfg_t;

  typedef struct packed {
    digits_t               digits;
    logic [AXIS_DIM_W-1:0] axis_dim;
    logic [2:0]            axis_step;
    logic                  axis_neg;
    logic [4:0]            table_idx;
    logic [POLE_W-1:0]     pole;
  } seq_state_t;

  typedef struct packed {
    offsets_t          off;
    logic [POLE_W-1:0] pole;
    logic              last;
    logic              bad;
  } result_t;

  localparam seq_state_t SEQ_RESET = '{
    digits:    '0,
    axis_dim:  '0,
    axis_step: 3'd1,
    axis_neg:  1'b0,
    table_idx: '0,
    pole:      '0
  };

  localparam logic signed [OFF_W-1:0] OFF_P = 4'sd1;
  localparam logic signed [OFF_W-1:0] OFF_N = -4'sd1;
  localparam logic signed [OFF_W-1:0] OFF_Z = 4'sd0;

  // 14-point 3D: six axis directions, then eight corners
  localparam logic signed [OFF_W-1:0] TAB14 [14][3] = '{
    '{OFF_P, OFF_Z, OFF_Z}, '{OFF_N, OFF_Z, OFF_Z},
    '{OFF_Z, OFF_P, OFF_Z}, '{OFF_Z, OFF_N, OFF_Z},
    '{OFF_Z, OFF_Z, OFF_P}, '{OFF_Z, OFF_Z, OFF_N},
    '{OFF_P, OFF_P, OFF_P}, '{OFF_P, OFF_P, OFF_N},
    '{OFF_P, OFF_N, OFF_P}, '{OFF_P, OFF_N, OFF_N},
    '{OFF_N, OFF_P, OFF_P}, '{OFF_N, OFF_P, OFF_N},
    '{OFF_N, OFF_N, OFF_P}, '{OFF_N, OFF_N, OFF_N}
  };

  // 24-cell 4D: axis pairs
  localparam logic [1:0] PAIR24 [6][2] = '{
    '{2'd0, 2'd1}, '{2'd0, 2'd2}, '{2'd0, 2'd3},
    '{2'd1, 2'd2}, '{2'd1, 2'd3}, '{2'd2, 2'd3}
  };

  // (2r+1)^d, indexed [r-1][d-1]
  localparam logic [POLE_W-1:0] FULL_POLES [MAX_RADIUS][MAX_DIMS] = '{
    '{16'd3,  16'd9,   16'd27,   16'd81},
    '{16'd5,  16'd25,  16'd125,  16'd625},
    '{16'd7,  16'd49,  16'd343,  16'd2401},
    '{16'd9,  16'd81,  16'd729,  16'd6561},
    '{16'd11, 16'd121, 16'd1331, 16'd14641},
    '{16'd13, 16'd169, 16'd2197, 16'd28561},
    '{16'd15, 16'd225, 16'd3375, 16'd50625}
  };

endpackage

### rtl/sos_pole_gen.sv
// Pole generator: offsets, last flag and successor state for one advance.
module sos_pole_gen (
  input  sos_pkg::cfg_t       cfg_i,
  input  sos_pkg::seq_state_t state_i,
  input  logic                restart_i,
  output sos_pkg::result_t    res_o,
  output sos_pkg::seq_state_t next_o
);

  function automatic sos_pkg::digits_t odo_step(sos_pkg::digits_t dg, logic [2:0] d,
                                                logic [2:0] r);
    sos_pkg::digits_t o;
    logic             carry;
    o     = dg;
    carry = 1'b1;
    for (int i = 0; i < sos_pkg::MAX_DIMS; i++) begin
      if (carry && (i < int'(d))) begin
        if (dg[i] == {r, 1'b0}) begin
          o[i] = '0;
        end else begin
          o[i]  = dg[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return o;
  endfunction

  function automatic logic at_centre(sos_pkg::digits_t dg, logic [2:0] d, logic [2:0] r);
    logic c;
    c = 1'b1;
    for (int i = 0; i < sos_pkg::MAX_DIMS; i++) begin
      if ((i < int'(d)) && (dg[i] != {1'b0, r})) c = 1'b0;
    end
    return c;
  endfunction

  sos_pkg::kind_e          kind;
  logic                    ok;
  sos_pkg::seq_state_t     cur;
  sos_pkg::seq_state_t     adv;
  sos_pkg::digits_t        odo1;
  logic [6:0]              axis_poles;
  logic [sos_pkg::POLE_W-1:0] count;
  logic [sos_pkg::POLE_W:0]   pole_inc;
  logic                    last;
  logic [2:0]              d;
  logic [2:0]              r;
  logic [4:0]              p;
  logic [2:0]              grp;
  logic [2:0]              r_idx;
  logic [2:0]              d_idx;
  sos_pkg::offsets_t       off;

  assign d          = cfg_i.dims;
  assign r          = cfg_i.radius;
  assign cur        = restart_i ? sos_pkg::SEQ_RESET : state_i;
  assign axis_poles = 7'(d) * 7'({r, 1'b0});
  assign r_idx      = r - 3'd1;
  assign d_idx      = d - 3'd1;
  assign pole_inc   = {1'b0, cur.pole} + 17'd1;
  assign odo1       = odo_step(cur.digits, d, r);

  always_comb begin
    ok   = (d != 3'd0) && (int'(d) <= sos_pkg::MAX_DIMS) &&
           (r != 3'd0) && (int'(r) <= sos_pkg::MAX_RADIUS);
    kind = sos_pkg::KIND_AXIS;
    case (cfg_i.kind)
      sos_pkg::KIND_DEFAULT:  kind = (d == 3'd2) ? sos_pkg::KIND_AXIS_CTR : sos_pkg::KIND_AXIS;
      sos_pkg::KIND_AXIS:     kind = sos_pkg::KIND_AXIS;
      sos_pkg::KIND_AXIS_CTR: kind = sos_pkg::KIND_AXIS_CTR;
      sos_pkg::KIND_FULL:     kind = sos_pkg::KIND_FULL;
      sos_pkg::KIND_FULL_CTR: kind = sos_pkg::KIND_FULL_CTR;
      sos_pkg::KIND_14PT: begin
        kind = sos_pkg::KIND_14PT;
        if (d != 3'd3 || r != 3'd1) ok = 1'b0;
      end
      sos_pkg::KIND_24CELL: begin
        kind = sos_pkg::KIND_24CELL;
        if (d != 3'd4 || r != 3'd1) ok = 1'b0;
      end
      default: ok = 1'b0;
    endcase
  end

  always_comb begin
    off   = '0;
    count = 16'd24;
    adv   = cur;
    p     = '0;
    grp   = '0;
    case (kind)
      sos_pkg::KIND_AXIS, sos_pkg::KIND_AXIS_CTR: begin
        count = 16'(axis_poles) + ((kind == sos_pkg::KIND_AXIS_CTR) ? 16'd1 : 16'd0);
        if ((cur.axis_dim < sos_pkg::AXIS_DIM_W'(d)) &&
            (int'(cur.axis_dim) < sos_pkg::MAX_DIMS)) begin
          off[cur.axis_dim[sos_pkg::DIM_IDX_W-1:0]] =
            cur.axis_neg ? (4'd0 - {1'b0, cur.axis_step}) : {1'b0, cur.axis_step};
        end
        if (!cur.axis_neg) begin
          adv.axis_neg = 1'b1;
        end else begin
          adv.axis_neg = 1'b0;
          if (cur.axis_step >= r) begin
            adv.axis_step = 3'd1;
            adv.axis_dim  = cur.axis_dim + 1'b1;
          end else begin
            adv.axis_step = cur.axis_step + 3'd1;
          end
        end
      end
      sos_pkg::KIND_FULL, sos_pkg::KIND_FULL_CTR: begin
        count = sos_pkg::FULL_POLES[r_idx][d_idx[1:0]] -
                ((kind == sos_pkg::KIND_FULL) ? 16'd1 : 16'd0);
        for (int i = 0; i < sos_pkg::OUT_DIMS && i < sos_pkg::MAX_DIMS; i++) begin
          if (i < int'(d)) off[i] = cur.digits[i] - {1'b0, r};
        end
        // the plain full cube steps over its centre
        if ((kind == sos_pkg::KIND_FULL) && at_centre(odo1, d, r))
          adv.digits = odo_step(odo1, d, r);
        else
          adv.digits = odo1;
      end
      sos_pkg::KIND_14PT: begin
        count = 16'd14;
        p     = (cur.table_idx < 5'd14) ? cur.table_idx : 5'd0;
        for (int i = 0; i < 3; i++) off[i] = sos_pkg::TAB14[p[3:0]][i];
        adv.table_idx = cur.table_idx + 5'd1;
      end
      default: begin
        count = 16'd24;
        p     = (cur.table_idx < 5'd24) ? cur.table_idx : 5'd0;
        grp   = p[4:2];
        off[sos_pkg::PAIR24[grp][0]] = p[1] ? sos_pkg::OFF_P : sos_pkg::OFF_N;
        off[sos_pkg::PAIR24[grp][1]] = p[0] ? sos_pkg::OFF_P : sos_pkg::OFF_N;
        adv.table_idx = cur.table_idx + 5'd1;
      end
    endcase
    adv.pole = cur.pole + 16'd1;
  end

  assign last = (pole_inc >= {1'b0, count});

  always_comb begin
    if (!ok) begin
      res_o  = '{off: '0, pole: '0, last: 1'b1, bad: 1'b1};
      next_o = sos_pkg::SEQ_RESET;
    end else begin
      res_o  = '{off: off, pole: cur.pole, last: last, bad: 1'b0};
      next_o = last ? sos_pkg::SEQ_RESET : adv;
    end
  end

endmodule

### rtl/stencil_offset_sequencer.sv
// Top level of the stencil offset sequencer: registers, handshakes, result stage.
//
//  channel   direction  handshake                 payload
//  in        sink       in_valid_i / in_stall_o   restart_i
//  out       source     out_valid_o / out_stall_i offset_x0..3, pole_index, last_pole,
//                                                 bad_config
//  cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle while in_stall_o is low; its result sits in the result register in the cycle after acceptance.
// The pole generator is one combinational pass from the sequence register.
// Reset: dims 3, radius 1, default kind, sequence at the first pole; no clearing pass.
// in_stall_o follows out_stall_i only while the result register holds an unclaimed item.
// A configuration write to a known register returns the sequence to its first pole.
`include "stencil_offset_sequencer_macros.svh"

module stencil_offset_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              restart_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [3:0] offset_x0_o,
  output logic signed [3:0] offset_x1_o,
  output logic signed [3:0] offset_x2_o,
  output logic signed [3:0] offset_x3_o,
  output logic [15:0]       pole_index_o,
  output logic              last_pole_o,
  output logic              bad_config_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [2:0]        cfg_data_i
);

  sos_pkg::cfg_t       cfg_q;
  sos_pkg::seq_state_t seq_q;
  sos_pkg::seq_state_t seq_d;
  sos_pkg::result_t    res_d;
  sos_pkg::result_t    res_q;
  logic                out_valid_q;
  logic                in_accept;
  logic                cfg_write;
  logic                cfg_clear;
  logic                res_blank;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;

  // only a write to a known register restarts the sequence
  assign cfg_clear = cfg_write && (cfg_index_i == sos_pkg::REG_DIMS ||
                                   cfg_index_i == sos_pkg::REG_RADIUS ||
                                   cfg_index_i == sos_pkg::REG_KIND);

  sos_pole_gen u_gen (
    .cfg_i     (cfg_q),
    .state_i   (seq_q),
    .restart_i (restart_i),
    .res_o     (res_d),
    .next_o    (seq_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{dims: 3'd3, radius: 3'd1, kind: sos_pkg::KIND_DEFAULT};
    end else if (cfg_write) begin
      case (cfg_index_i)
        sos_pkg::REG_DIMS:   cfg_q.dims   <= cfg_data_i;
        sos_pkg::REG_RADIUS: cfg_q.radius <= cfg_data_i;
        sos_pkg::REG_KIND:   cfg_q.kind   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= sos_pkg::SEQ_RESET;
    end else if (cfg_clear) begin
      seq_q <= sos_pkg::SEQ_RESET;
    end else if (in_accept) begin
      seq_q <= seq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign offset_x0_o  = res_q.off[0];
  assign offset_x1_o  = res_q.off[1];
  assign offset_x2_o  = res_q.off[2];
  assign offset_x3_o  = res_q.off[3];
  assign pole_index_o = res_q.pole;
  assign last_pole_o  = res_q.last;
  assign bad_config_o = res_q.bad;

  assign res_blank = (res_q.off == '0) && (res_q.pole == '0) && res_q.last;

  `SOS_ASSERT_NOW(a_bad_shape, out_valid_o && bad_config_o, res_blank, "bad config item not blank")
  `SOS_ASSERT_NEXT(a_restart_first, in_accept && restart_i, pole_index_o == '0, "restart not at pole 0")
  `SOS_ASSERT_NEXT(a_accept_shows, in_accept, out_valid_o, "accepted item has no result")
  `SOS_ASSERT_NEXT(a_cfg_clears, cfg_clear, seq_q == sos_pkg::SEQ_RESET, "sequence not reset by write")

endmodule
